// File: rtl/gccc_pkg.sv
// ----------------------------------------------------------------------------
// gccc_pkg
// shared types, constants and helpers of the coast cell counter
// ----------------------------------------------------------------------------
`default_nettype none

package gccc_pkg;

   // default size limits of the map
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   // field widths
   localparam int CHAR_W      = 8;
   localparam int CFG_W       = 11;
   localparam int COUNT_W     = 21;
   localparam int CSR_INDEX_W = 1;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 24;

   // cell bytes
   localparam logic [CHAR_W-1:0] CHAR_LAND  = 8'd35;
   localparam logic [CHAR_W-1:0] CHAR_WATER = 8'd46;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MAP_HEIGHT = 1'b0,
      REG_MAP_WIDTH  = 1'b1
   } csr_index_type;

   // cell class kept in the row store
   typedef enum logic [1:0] {
      CLS_OTHER = 2'd0,
      CLS_LAND  = 2'd1,
      CLS_WATER = 2'd2
   } class_type;

   // one row store entry: class two rows up and one row up
   typedef struct packed {
      class_type upper;
      class_type middle;
   } line_entry_type;

   // position flags of the incoming cell, handed to the judging stage
   typedef struct packed {
      logic first_row;
      logic second_row;
      logic last_row;
      logic first_col;
      logic last_col;
      logic frame_last;
   } cell_ctl_type;

   function automatic class_type classify(input logic [CHAR_W-1:0] ch);
      class_type c;
      if (ch == CHAR_LAND) begin
         c = CLS_LAND;
      end else if (ch == CHAR_WATER) begin
         c = CLS_WATER;
      end else begin
         c = CLS_OTHER;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: rtl/gccc_line_mem.sv
// ----------------------------------------------------------------------------
// gccc_line_mem
// row store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module gccc_line_mem #(
   parameter int DEPTH  = gccc_pkg::DEF_MAX_WIDTH,
   parameter int ADDR_W = 10
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire gccc_pkg::line_entry_type wr_data,
   input  wire logic                     rd_en,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output gccc_pkg::line_entry_type      rd_data
);

   gccc_pkg::line_entry_type mem [DEPTH];
   gccc_pkg::line_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/gccc_judge.sv
// ----------------------------------------------------------------------------
// gccc_judge
// judging stage: classifies the cell above the incoming one, counts land cells of the last row and keeps the count
// ----------------------------------------------------------------------------
`default_nettype none

module gccc_judge (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            restart,
   input  wire logic                            valid,
   input  wire gccc_pkg::class_type             cls,
   input  wire gccc_pkg::cell_ctl_type          ctl,
   input  wire gccc_pkg::line_entry_type        rd_data,
   input  wire logic                            fwd_hit,
   input  wire gccc_pkg::line_entry_type        fwd_data,
   output gccc_pkg::line_entry_type             wr_data,
   output logic                                 res_valid,
   output logic [gccc_pkg::COUNT_W-1:0]         res_count
);

   gccc_pkg::line_entry_type cur_ent_ff, cur_ent_in;
   gccc_pkg::class_type      left_ff, left_in;
   logic [gccc_pkg::COUNT_W-1:0] count_ff, count_in;

   gccc_pkg::line_entry_type nxt_ent;
   gccc_pkg::class_type      above;
   logic                     judged;
   logic                     bottom_land;
   logic [gccc_pkg::COUNT_W-1:0] sum;

   always_comb begin
      above = cur_ent_ff.middle;

      // store write: current row moves to the upper slot, new class to middle
      wr_data.upper  = ctl.first_row ? cur_ent_ff.upper : above;
      wr_data.middle = cls;

      // entry of the next column, with bypass of writes the read missed
      nxt_ent = fwd_hit ? fwd_data : rd_data;
      if (ctl.first_col && ctl.last_col) begin
         nxt_ent = wr_data;
      end

      judged = !ctl.first_row && (above == gccc_pkg::CLS_LAND) &&
               (ctl.second_row || ctl.first_col || ctl.last_col ||
                (cls == gccc_pkg::CLS_WATER) ||
                (!ctl.second_row && (cur_ent_ff.upper == gccc_pkg::CLS_WATER)) ||
                (!ctl.first_col && (left_ff == gccc_pkg::CLS_WATER)) ||
                (!ctl.last_col && (nxt_ent.middle == gccc_pkg::CLS_WATER)));
      bottom_land = ctl.last_row && (cls == gccc_pkg::CLS_LAND);

      sum = count_ff + gccc_pkg::COUNT_W'(judged) + gccc_pkg::COUNT_W'(bottom_land);

      cur_ent_in = cur_ent_ff;
      left_in    = left_ff;
      count_in   = count_ff;
      if (valid) begin
         cur_ent_in = nxt_ent;
         if (ctl.last_col) begin
            left_in = gccc_pkg::CLS_OTHER;
         end else if (!ctl.first_row) begin
            left_in = above;
         end
         count_in = ctl.frame_last ? '0 : sum;
      end
      if (restart) begin
         left_in  = gccc_pkg::CLS_OTHER;
         count_in = '0;
      end

      res_valid = valid && ctl.frame_last;
      res_count = sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= gccc_pkg::CLS_OTHER;
         count_ff <= '0;
      end else begin
         left_ff  <= left_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ent_ff <= cur_ent_in;
   end

endmodule

`default_nettype wire

// File: rtl/gccc_rsp_queue.sv
// ----------------------------------------------------------------------------
// gccc_rsp_queue
// result register with one skid entry behind it
// ----------------------------------------------------------------------------
`default_nettype none

module gccc_rsp_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire logic [gccc_pkg::COUNT_W-1:0] push_data,
   input  wire logic                        pop_ready,
   output logic                             out_valid,
   output logic [gccc_pkg::COUNT_W-1:0]     out_data,
   output logic                             skid_valid
);

   logic                         rsp_v_ff, rsp_v_in;
   logic                         skid_v_ff, skid_v_in;
   logic [gccc_pkg::COUNT_W-1:0] rsp_d_ff, rsp_d_in;
   logic [gccc_pkg::COUNT_W-1:0] skid_d_ff, skid_d_in;
   logic                         pop;

   always_comb begin
      pop       = rsp_v_ff && pop_ready;
      rsp_v_in  = rsp_v_ff;
      rsp_d_in  = rsp_d_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      if (pop) begin
         rsp_v_in  = skid_v_ff;
         rsp_d_in  = skid_d_ff;
         skid_v_in = 1'b0;
      end
      if (push) begin
         if (!rsp_v_in) begin
            rsp_v_in = 1'b1;
            rsp_d_in = push_data;
         end else begin
            skid_v_in = 1'b1;
            skid_d_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         rsp_v_ff  <= rsp_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_d_ff  <= rsp_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign out_valid  = rsp_v_ff;
   assign out_data   = rsp_d_ff;
   assign skid_valid = skid_v_ff;

endmodule

`default_nettype wire

// File: rtl/grid_coast_cell_counter.sv
// ----------------------------------------------------------------------------
// grid_coast_cell_counter
// counts land cells of a streamed character map that touch water or the border
// ----------------------------------------------------------------------------
// The map streams in one byte per transaction in raster order; map_height and
// map_width are set through the csr port (0 acts as 1, values above the size
// limit act as the limit) and every csr write restarts the frame. After the
// last cell of a frame one transaction on rsp carries the coast count and the
// next frame starts from zero. One cell is taken every clock while req_tready
// is high: each transaction reads the row store one column ahead and the
// judging stage writes the cell's column back in the next cycle, so the single
// read and single write port of the row store set the rate. Results queue in
// an output register and a skid entry; req_tready drops only while both slots
// are taken or about to be, so it never drops while rsp_tready stays high and
// stalls the input only when the consumer falls behind. The row store needs no
// clearing pass, so the block is ready right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_coast_cell_counter #(
   parameter int MAX_WIDTH  = gccc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gccc_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input cells
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [gccc_pkg::REQ_DATA_W-1:0]     req_tdata,   // [7:0] cell_char
   // results
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [gccc_pkg::RSP_DATA_W-1:0]          rsp_tdata,   // [20:0] coast_count
   // configuration writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [gccc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [gccc_pkg::CFG_W-1:0]          csr_data
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   // size registers, kept as last index
   logic [COL_W-1:0] width_last_ff, width_last_in;
   logic [ROW_W-1:0] height_last_ff, height_last_in;

   // raster position of the next incoming cell
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // judging stage inputs
   logic                     s1_valid_ff;
   gccc_pkg::class_type      s1_cls_ff;
   gccc_pkg::cell_ctl_type   s1_ctl_ff;
   logic [COL_W-1:0]         s1_col_ff;
   logic                     s1_fwd_ff;
   gccc_pkg::line_entry_type s1_fwd_data_ff;

   logic                     req_fire;
   logic                     csr_fire;
   gccc_pkg::cell_ctl_type   ctl;
   logic [COL_W-1:0]         next_col;
   logic                     fwd_hit_in;

   gccc_pkg::line_entry_type rd_data;
   gccc_pkg::line_entry_type wr_data;
   logic                     res_valid;
   logic [gccc_pkg::COUNT_W-1:0] res_count;
   logic [gccc_pkg::COUNT_W-1:0] out_count;
   logic                     skid_valid;
   logic                     s1_last;
   logic                     rsp_pop;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_pop   = rsp_tvalid && rsp_tready;

   // at most one free result slot may be claimed by a new transaction;
   // a result leaving this cycle frees its slot, unless a frame ends while the skid entry is taken
   assign s1_last    = s1_valid_ff && s1_ctl_ff.frame_last;
   assign req_tready = !((rsp_tvalid && skid_valid && !rsp_pop) ||
                         (rsp_tvalid && s1_last && !rsp_pop) ||
                         (skid_valid && s1_last));

   // size registers, clamped on write
   always_comb begin
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      if (csr_fire) begin
         unique case (gccc_pkg::csr_index_type'(csr_index))
            gccc_pkg::REG_MAP_HEIGHT: begin
               if (csr_data == '0) begin
                  height_last_in = '0;
               end else if (32'(csr_data) > MAX_HEIGHT) begin
                  height_last_in = ROW_W'(MAX_HEIGHT - 1);
               end else begin
                  height_last_in = ROW_W'(csr_data - 1'b1);
               end
            end
            gccc_pkg::REG_MAP_WIDTH: begin
               if (csr_data == '0) begin
                  width_last_in = '0;
               end else if (32'(csr_data) > MAX_WIDTH) begin
                  width_last_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  width_last_in = COL_W'(csr_data - 1'b1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // position flags and raster advance
   always_comb begin
      ctl.first_row  = (row_ff == '0);
      ctl.second_row = (row_ff == ROW_W'(1));
      ctl.last_row   = (row_ff == height_last_ff);
      ctl.first_col  = (col_ff == '0);
      ctl.last_col   = (col_ff == width_last_ff);
      ctl.frame_last = ctl.last_row && ctl.last_col;

      next_col = ctl.last_col ? '0 : col_ff + 1'b1;

      // the store write of this cycle lands after the read of next_col
      fwd_hit_in = s1_valid_ff && (s1_col_ff == next_col);

      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         col_in = next_col;
         if (ctl.last_col) begin
            row_in = ctl.last_row ? '0 : row_ff + 1'b1;
         end
      end
      if (csr_fire) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= '0;
         height_last_ff <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         width_last_ff  <= width_last_in;
         height_last_ff <= height_last_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         s1_valid_ff    <= req_fire;
      end
   end

   // judging stage payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cls_ff      <= gccc_pkg::classify(req_tdata[gccc_pkg::CHAR_W-1:0]);
         s1_ctl_ff      <= ctl;
         s1_col_ff      <= col_ff;
         s1_fwd_ff      <= fwd_hit_in;
         s1_fwd_data_ff <= wr_data;
      end
   end

   // row store, read one column ahead of the incoming cell
   gccc_line_mem #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (next_col),
      .rd_data (rd_data)
   );

   gccc_judge u_judge (
      .clock     (clock),
      .reset     (reset),
      .restart   (csr_fire),
      .valid     (s1_valid_ff),
      .cls       (s1_cls_ff),
      .ctl       (s1_ctl_ff),
      .rd_data   (rd_data),
      .fwd_hit   (s1_fwd_ff),
      .fwd_data  (s1_fwd_data_ff),
      .wr_data   (wr_data),
      .res_valid (res_valid),
      .res_count (res_count)
   );

   gccc_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res_count),
      .pop_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_data   (out_count),
      .skid_valid (skid_valid)
   );

   assign rsp_tdata = {(gccc_pkg::RSP_DATA_W - gccc_pkg::COUNT_W)'(0), out_count};

endmodule

`default_nettype wire
